// ----- design/gfau_pkg.sv -----
// Shared types, operation codes and GF(2^8) helper functions for the
// arithmetic unit (reduction polynomial 0x11D). No dependencies.
package gfau_pkg;

    localparam int unsigned ElemW = 8;
    localparam int unsigned FuncW = 3;
    localparam int unsigned ProdW = 2 * ElemW - 1;
    localparam logic [ElemW:0] GfPoly = 9'h11D;

    typedef enum logic [FuncW-1:0] {
        FN_ADD = 3'd0,
        FN_DBL = 3'd1,
        FN_MUL = 3'd2,
        FN_SQR = 3'd3,
        FN_INV = 3'd4
    } t_func;

    typedef logic [ElemW-1:0] t_elem;

    // Input stage contents
    typedef struct packed {
        logic [FuncW-1:0] func;
        t_elem            a;
        t_elem            b;
    } t_in;

    // Working stage contents; v is the running value (final result when !inv)
    typedef struct packed {
        logic  inv;
        t_elem a;
        t_elem p3;
        t_elem v;
    } t_stage;

    function automatic t_elem gf_reduce(logic [ProdW-1:0] v);
        logic [ProdW-1:0] t;
        t = v;
        for (int i = ProdW - 1; i >= ElemW; i--) begin
            if (t[i]) begin
                t = t ^ (ProdW'(GfPoly) << (i - ElemW));
            end
        end
        return t[ElemW-1:0];
    endfunction

    function automatic t_elem gf_mul(t_elem a, t_elem b);
        logic [ProdW-1:0] acc;
        acc = '0;
        for (int i = 0; i < ElemW; i++) begin
            if (b[i]) begin
                acc = acc ^ (ProdW'(a) << i);
            end
        end
        return gf_reduce(acc);
    endfunction

    // Squaring is linear: spread bits, then reduce
    function automatic t_elem gf_sqr(t_elem a);
        logic [ProdW-1:0] s;
        s = '0;
        for (int i = 0; i < ElemW; i++) begin
            s[2*i] = a[i];
        end
        return gf_reduce(s);
    endfunction

    function automatic t_elem gf_dbl(t_elem a);
        return gf_reduce(ProdW'({a, 1'b0}));
    endfunction

endpackage

// ----- design/gf256_arithmetic_unit_core.sv -----
// GF(2^8) arithmetic unit core: add, double, multiply, square, inverse.
// Five-stage pipeline; depends on gfau_pkg.
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+------------------------------------------
//  in      | i_valid  | o_stall  | i_func, i_operand_a, i_operand_b
//  out     | o_valid  | i_stall  | o_result
//
// One transaction per cycle sustained while i_stall is low; every opcode takes the same path.
// Inverse is a^254: one GF multiply per stage in stages 1-4 sets the depth.
// Reset (synchronous, active low) empties the pipeline; no clearing pass.
// A stalled output holds; bubbles are squeezed out, so o_stall rises only
// when all five stages are full and i_stall is high.
module gf256_arithmetic_unit_core
    import gfau_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [FuncW-1:0] i_func,
    input  logic [ElemW-1:0] i_operand_a,
    input  logic [ElemW-1:0] i_operand_b,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [ElemW-1:0] o_result
);

    localparam int unsigned NStg = 5;

    logic [NStg-1:0] r_vld;
    logic [NStg-1:0] w_rdy;

    t_in    r_in;
    t_stage r_s1, r_s2, r_s3, r_s4;
    t_stage n_s1, n_s2, n_s3, n_s4;

    // Stage k advances when empty or when the stage after it advances
    always_comb begin
        w_rdy[NStg-1] = !r_vld[NStg-1] || !i_stall;
        for (int k = NStg - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_stall  = !w_rdy[0];
    assign o_valid  = r_vld[NStg-1];
    assign o_result = r_s4.v;

    // Stage 1: all single-step ops finish here; inverse starts with a^3
    always_comb begin
        n_s1.inv = 1'b0;
        n_s1.a   = r_in.a;
        n_s1.p3  = '0;
        unique case (r_in.func)
            FN_ADD:  n_s1.v = r_in.a ^ r_in.b;
            FN_DBL:  n_s1.v = gf_dbl(r_in.a);
            FN_MUL:  n_s1.v = gf_mul(r_in.a, r_in.b);
            FN_SQR:  n_s1.v = gf_sqr(r_in.a);
            FN_INV: begin
                n_s1.inv = 1'b1;
                n_s1.v   = gf_mul(gf_sqr(r_in.a), r_in.a);
                n_s1.p3  = n_s1.v;
            end
            default: n_s1.v = '0;
        endcase
    end

    // Stage 2: a^15
    always_comb begin
        n_s2 = r_s1;
        if (r_s1.inv) begin
            n_s2.v = gf_mul(gf_sqr(gf_sqr(r_s1.v)), r_s1.p3);
        end
    end

    // Stage 3: a^63
    always_comb begin
        n_s3 = r_s2;
        if (r_s2.inv) begin
            n_s3.v = gf_mul(gf_sqr(gf_sqr(r_s2.v)), r_s2.p3);
        end
    end

    // Stage 4: a^127 then a^254
    always_comb begin
        n_s4 = r_s3;
        if (r_s3.inv) begin
            n_s4.v = gf_sqr(gf_mul(gf_sqr(r_s3.v), r_s3.a));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NStg; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_in.func <= i_func;
            r_in.a    <= i_operand_a;
            r_in.b    <= i_operand_b;
        end
        if (w_rdy[1]) begin
            r_s1 <= n_s1;
        end
        if (w_rdy[2]) begin
            r_s2 <= n_s2;
        end
        if (w_rdy[3]) begin
            r_s3 <= n_s3;
        end
        if (w_rdy[4]) begin
            r_s4 <= n_s4;
        end
    end

`ifndef SYNTH
    // Backpressure only when every stage holds a transaction
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("o_stall with an empty pipeline stage");

    // An accepted transaction lands in the input stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transaction lost at input stage");

    // Stalled output transaction is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled output dropped");

    // Non-inverse results pass stage 2 untouched
    a_pass_thru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !r_s1.inv && w_rdy[2]) |=> (r_s2.v == $past(r_s1.v)))
        else $error("non-inverse value altered in stage 2");
`endif

endmodule
